// ----- src/octr_pkg.sv -----
// Shared types, constants and reset values for the overcurrent trip/retry controller.
package octr_pkg;

    localparam int TIMER_WIDTH_DEF = 17;

    localparam int CUR_W      = 16;
    localparam int DELAY_W    = 16;
    localparam int LIMIT_W    = 8;
    localparam int SCALED_W   = 20;
    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 16;

    localparam int MARGIN_HIGH_NUM = 11;
    localparam int MARGIN_LOW_NUM  = 9;
    localparam int MARGIN_DEN      = 10;

    localparam logic [CUR_W-1:0]   MAX_CURRENT_RST = 16'd10000;
    localparam logic [DELAY_W-1:0] TRIP_DELAY_RST  = 16'd10;
    localparam logic [DELAY_W-1:0] RETRY_WAIT_RST  = 16'd1000;
    localparam logic [LIMIT_W-1:0] RETRY_LIMIT_RST = 8'd3;

    localparam logic [CFG_INDEX_W-1:0] REG_MAX_CURRENT = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_TRIP_DELAY  = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_RETRY_WAIT  = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_RETRY_LIMIT = 8'd3;

    typedef enum logic [1:0] {
        ST_IDLE   = 2'd0,
        ST_WAIT   = 2'd1,
        ST_TRYING = 2'd2,
        ST_FAIL   = 2'd3
    } state_t;

    typedef enum logic [1:0] {
        ACT_NONE  = 2'd0,
        ACT_OFF   = 2'd1,
        ACT_RETRY = 2'd2
    } action_t;

    typedef struct packed {
        logic [CUR_W-1:0]   max_current_ma;
        logic [DELAY_W-1:0] trip_delay_ms;
        logic [DELAY_W-1:0] retry_wait_ms;
        logic [LIMIT_W-1:0] retry_limit;
    } cfg_t;

endpackage

// ----- src/octr_tick_if.sv -----
// Tick channel: one current sample and turn-on request per beat.
interface octr_tick_if;
    logic        valid;
    logic        ready;
    logic [15:0] current_ma;
    logic        turn_on;

    modport source (output valid, output current_ma, output turn_on, input ready);
    modport sink   (input valid, input current_ma, input turn_on, output ready);
endinterface

// ----- src/octr_result_if.sv -----
// Result channel: controller state after each tick.
interface octr_result_if;
    logic       valid;
    logic       ready;
    logic [1:0] retry_state;
    logic       output_on;
    logic [1:0] drive_action;
    logic [7:0] retries_used;

    modport source (output valid, output retry_state, output output_on,
                    output drive_action, output retries_used, input ready);
    modport sink   (input valid, input retry_state, input output_on,
                    input drive_action, input retries_used, output ready);
endinterface

// ----- src/octr_cfg_if.sv -----
// Configuration write channel: register index and write data.
interface octr_cfg_if;
    logic        valid;
    logic        ready;
    logic [7:0]  index;
    logic [15:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- src/octr_step.sv -----
// Per-tick next-state logic: timer, overcurrent detect/cancel, trip and retry.
module octr_step #(
    parameter int TIMER_WIDTH = octr_pkg::TIMER_WIDTH_DEF
) (
    input  octr_pkg::cfg_t                 cfg,
    input  logic [octr_pkg::CUR_W-1:0]     current_ma,
    input  logic                           turn_on,
    input  octr_pkg::state_t               state,
    input  logic                           on_flag,
    input  logic [TIMER_WIDTH-1:0]         timer,
    input  logic [octr_pkg::LIMIT_W-1:0]   retry_cnt,
    output octr_pkg::state_t               state_next,
    output logic                           on_next,
    output logic [TIMER_WIDTH-1:0]         timer_next,
    output logic [octr_pkg::LIMIT_W-1:0]   retry_cnt_next,
    output octr_pkg::action_t              action
);
    import octr_pkg::*;

    logic [SCALED_W-1:0] scaled;
    logic [SCALED_W-1:0] limit_high;
    logic [SCALED_W-1:0] limit_low;

    assign scaled     = SCALED_W'(current_ma) * SCALED_W'(MARGIN_DEN);
    assign limit_high = SCALED_W'(cfg.max_current_ma) * SCALED_W'(MARGIN_HIGH_NUM);
    assign limit_low  = SCALED_W'(cfg.max_current_ma) * SCALED_W'(MARGIN_LOW_NUM);

    always_comb
    begin
        state_next     = state;
        on_next        = on_flag | turn_on;
        retry_cnt_next = retry_cnt;
        action         = ACT_NONE;
        // saturating tick count
        timer_next     = (timer != '1) ? timer + TIMER_WIDTH'(1) : timer;

        if (on_next && (scaled > limit_high) &&
            ((state_next == ST_IDLE) || (state_next == ST_TRYING)))
        begin
            timer_next = '0;
            state_next = ST_WAIT;
        end
        if ((state_next == ST_WAIT) && (scaled < limit_low))
        begin
            state_next     = ST_IDLE;
            retry_cnt_next = '0;
        end

        if ((state_next == ST_WAIT) && (32'(timer_next) > 32'(cfg.trip_delay_ms)))
        begin
            action     = ACT_OFF;
            on_next    = 1'b0;
            timer_next = '0;
            state_next = ST_TRYING;
        end
        if ((state_next == ST_TRYING) && (32'(timer_next) > 32'(cfg.retry_wait_ms)))
        begin
            if (retry_cnt_next < cfg.retry_limit)
            begin
                retry_cnt_next = retry_cnt_next + LIMIT_W'(1);
                action         = ACT_RETRY;
                on_next        = 1'b1;
                timer_next     = '0;
            end
            else
            begin
                state_next = ST_FAIL;
            end
        end
    end

endmodule

// ----- src/overcurrent_trip_retry_controller.sv -----
// Top level of the overcurrent trip and auto-retry controller.
//
//   channel  dir  payload                                           beat when
//   tick     in   current_ma[15:0], turn_on                         valid & ready
//   result   out  retry_state[1:0], output_on, drive_action[1:0],   valid & ready
//                 retries_used[7:0]
//   cfg      in   index[7:0], data[15:0]                            valid & ready
//
// One tick beat per clock unless the result register stalls; a result
// passes the input register, then the result register. The per-tick
// update is one pass of compare and counter logic between the two registers.
// Reset clears the state, the timer, the retry count and restores register
// defaults. A stalled result register holds the tick register, which in turn
// drops tick ready; cfg is always ready.
module overcurrent_trip_retry_controller #(
    parameter int TIMER_WIDTH = octr_pkg::TIMER_WIDTH_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    octr_tick_if.sink     tick,
    octr_result_if.source result,
    octr_cfg_if.sink      cfg
);
    import octr_pkg::*;

    cfg_t                 cfg_reg;

    state_t               state_reg;
    logic                 on_reg;
    logic [TIMER_WIDTH-1:0] timer_reg;
    logic [LIMIT_W-1:0]   retry_cnt_reg;

    state_t               state_next;
    logic                 on_next;
    logic [TIMER_WIDTH-1:0] timer_next;
    logic [LIMIT_W-1:0]   retry_cnt_next;
    action_t              action;

    logic                 in_vld_reg;
    logic [CUR_W-1:0]     cur_reg;
    logic                 req_reg;

    logic                 out_vld_reg;
    state_t               res_state_reg;
    logic                 res_on_reg;
    action_t              res_action_reg;
    logic [LIMIT_W-1:0]   res_retries_reg;

    logic                 advance;

    // process the held tick when the result register is free or draining
    assign advance    = in_vld_reg && (!out_vld_reg || result.ready);
    assign tick.ready = !in_vld_reg || advance;
    assign cfg.ready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_current_ma <= MAX_CURRENT_RST;
            cfg_reg.trip_delay_ms  <= TRIP_DELAY_RST;
            cfg_reg.retry_wait_ms  <= RETRY_WAIT_RST;
            cfg_reg.retry_limit    <= RETRY_LIMIT_RST;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_MAX_CURRENT: cfg_reg.max_current_ma <= cfg.data;
                REG_TRIP_DELAY:  cfg_reg.trip_delay_ms  <= cfg.data;
                REG_RETRY_WAIT:  cfg_reg.retry_wait_ms  <= cfg.data;
                REG_RETRY_LIMIT: cfg_reg.retry_limit    <= cfg.data[LIMIT_W-1:0];
                default:         ;
            endcase
        end
    end

    octr_step #(
        .TIMER_WIDTH (TIMER_WIDTH)
    ) u_step (
        .cfg            (cfg_reg),
        .current_ma     (cur_reg),
        .turn_on        (req_reg),
        .state          (state_reg),
        .on_flag        (on_reg),
        .timer          (timer_reg),
        .retry_cnt      (retry_cnt_reg),
        .state_next     (state_next),
        .on_next        (on_next),
        .timer_next     (timer_next),
        .retry_cnt_next (retry_cnt_next),
        .action         (action)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            on_reg        <= 1'b0;
            timer_reg     <= '0;
            retry_cnt_reg <= '0;
            in_vld_reg    <= 1'b0;
            out_vld_reg   <= 1'b0;
        end
        else
        begin
            if (tick.ready)
            begin
                in_vld_reg <= tick.valid;
            end
            if (advance)
            begin
                state_reg     <= state_next;
                on_reg        <= on_next;
                timer_reg     <= timer_next;
                retry_cnt_reg <= retry_cnt_next;
                out_vld_reg   <= 1'b1;
            end
            else if (result.ready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (tick.valid && tick.ready)
        begin
            cur_reg <= tick.current_ma;
            req_reg <= tick.turn_on;
        end
        if (advance)
        begin
            res_state_reg   <= state_next;
            res_on_reg      <= on_next;
            res_action_reg  <= action;
            res_retries_reg <= retry_cnt_next;
        end
    end

    assign result.valid        = out_vld_reg;
    assign result.retry_state  = res_state_reg;
    assign result.output_on    = res_on_reg;
    assign result.drive_action = res_action_reg;
    assign result.retries_used = res_retries_reg;

    // only reset leaves the fail state
    a_fail_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_FAIL |=> state_reg == ST_FAIL)
        else $error("fail state left without reset");

    a_off_means_off: assert property (@(posedge clk) disable iff (!rst_n)
        (out_vld_reg && res_action_reg == ACT_OFF) |->
        (!res_on_reg && res_state_reg == ST_TRYING))
        else $error("switch-off beat with output still on");

    a_retry_means_on: assert property (@(posedge clk) disable iff (!rst_n)
        (out_vld_reg && res_action_reg == ACT_RETRY) |->
        (res_on_reg && res_state_reg == ST_TRYING && res_retries_reg != '0))
        else $error("retry beat inconsistent with state");

    a_state_only_on_advance: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> ($stable(state_reg) && $stable(retry_cnt_reg)))
        else $error("state changed without a processed tick");

endmodule
